// ----- src/sparse_bitmap_rank_select_unit_assert.svh -----
// Assertion macros for the sparse bitmap rank/select unit.
// Each macro builds a clocked implication with a disable on the active-low reset.
`ifndef SPARSE_BITMAP_RANK_SELECT_UNIT_ASSERT_SVH
`define SPARSE_BITMAP_RANK_SELECT_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication
`define SBRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbrs: same-cycle check failed");
// Next-cycle implication
`define SBRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbrs: next-cycle check failed");
`else
`define SBRS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/sbrs_pkg.sv -----
// Shared types and constants of the sparse bitmap rank/select unit.
// No dependencies; used by sbrs_popcnt and the top level.
`timescale 1ns / 1ps

package sbrs_pkg;

  // Population counter operand and result widths
  localparam int POP_W   = 64;
  localparam int CNT_W   = 7;
  localparam int FIELD_W = 6;

  typedef logic [POP_W-1:0]   pop_word_t;
  typedef logic [CNT_W-1:0]   pop_cnt_t;
  typedef logic [FIELD_W-1:0] field_t;

  // Operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_RANK   = 4'b0100,
    ST_SELECT = 4'b1000
  } state_e;

endpackage

// ----- src/sparse_bitmap_rank_select_unit.sv -----
// Top level of the sparse bitmap rank/select unit: presence words, sequencer
// and result register. Depends on sbrs_pkg, sbrs_popcnt and the assert header.
`timescale 1ns / 1ps
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+---------------------------------------
//  command   | start (in), busy (out)      | op_i, chunk_value_i, slot_position_i
//  result    | result_valid_o (one cycle)  | was_present_o, rank_o, removed_chunk_o,
//            |                             | node_empty_o, fault_o
//
//  Insert and lookup make one pass of the shared popcount per presence word,
//  then one masked count of the chunk's word (with the write on insert). Remove
//  makes the same scan, then walks the selected word a byte per step; a faulting
//  remove or a chunk beyond capacity ends after the scan. Clear is done in idle
//  and never raises busy. The result strobe rises the cycle after the last step,
//  when busy is already low. Reset clears the bitmap at once; results cannot stall.

`include "sparse_bitmap_rank_select_unit_assert.svh"

module sparse_bitmap_rank_select_unit #(
  parameter int CHUNK_WIDTH = 6,
  parameter int WORD_BITS   = 63,
  parameter int NUM_WORDS   = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op_i,
  input  logic [5:0] chunk_value_i,
  input  logic [5:0] slot_position_i,
  output logic       result_valid_o,
  output logic       was_present_o,
  output logic [5:0] rank_o,
  output logic [5:0] removed_chunk_o,
  output logic       node_empty_o,
  output logic       fault_o
);

  localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int NUM_BYTES  = (WORD_BITS + 7) / 8;
  localparam int BYTE_IDX_W = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
  localparam int TOT_W      = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int ACC_W      = (TOT_W > sbrs_pkg::CNT_W) ? TOT_W : sbrs_pkg::CNT_W;
  localparam logic [5:0] CHUNK_MASK =
    (CHUNK_WIDTH >= 6) ? 6'h3F : 6'((1 << CHUNK_WIDTH) - 1);

  // Sequencer and item registers
  sbrs_pkg::state_e        state_q, state_d;
  sbrs_pkg::op_e           op_q, op_d;
  logic [WIDX_W-1:0]       chunk_word_q, chunk_word_d;
  logic [BIT_IDX_W-1:0]    chunk_bit_q, chunk_bit_d;
  logic                    in_range_q, in_range_d;
  sbrs_pkg::field_t        pos_q, pos_d;
  logic [WIDX_W-1:0]       widx_q, widx_d;
  logic [ACC_W-1:0]        tot_q, tot_d;
  logic [ACC_W-1:0]        rank_acc_q, rank_acc_d;
  logic                    found_q, found_d;
  logic [WIDX_W-1:0]       sel_word_q, sel_word_d;
  sbrs_pkg::field_t        need_q, need_d;
  logic [BYTE_IDX_W-1:0]   byte_q, byte_d;

  // Presence words
  logic [WORD_BITS-1:0]    words_q [NUM_WORDS];
  logic                    wr_en;
  logic                    clr_all;
  logic [WIDX_W-1:0]       wr_idx;
  logic [WORD_BITS-1:0]    wr_data;

  // Result register
  logic                    res_valid_q, res_valid_d;
  logic                    was_q, was_d;
  sbrs_pkg::field_t        rank_q, rank_d;
  sbrs_pkg::field_t        removed_q, removed_d;
  logic                    empty_q, empty_d;
  logic                    fault_q, fault_d;

  // Datapath signals
  logic [5:0]              chunk_m;
  logic [2:0]              chunk_div;
  logic [9:0]              chunk_rem;
  logic [WIDX_W-1:0]       rd_idx;
  logic [WORD_BITS-1:0]    word_rd;
  sbrs_pkg::pop_word_t     word_pad;
  sbrs_pkg::pop_word_t     below_mask;
  sbrs_pkg::pop_word_t     pop_opnd;
  sbrs_pkg::pop_cnt_t      pop_cnt;
  logic [7:0]              byte_slice;
  logic [3:0]              loc_cnt;
  logic [2:0]              loc_j;
  logic                    loc_hit;
  logic [ACC_W:0]          scan_sum;
  logic [ACC_W-1:0]        rank_sum;
  logic [ACC_W-1:0]        need_full;
  logic                    scan_hit;
  logic                    scan_last;
  logic                    is_rank_op;
  logic [BIT_IDX_W-1:0]    sel_bit;
  logic [15:0]             removed_full;

  assign busy = (state_q != sbrs_pkg::ST_IDLE);

  // Split the masked chunk into word and bit index
  always_comb begin
    chunk_m   = chunk_value_i & CHUNK_MASK;
    chunk_div = '0;
    for (int k = 1; k < 8; k++) begin
      if (10'(chunk_m) >= 10'(k * WORD_BITS)) begin
        chunk_div = 3'(k);
      end
    end
    chunk_rem = 10'(chunk_m) - 10'(chunk_div) * 10'(WORD_BITS);
  end

  // Pick the word the current step reads
  always_comb begin
    priority if (state_q == sbrs_pkg::ST_SELECT) begin
      rd_idx = sel_word_q;
    end else if (state_q == sbrs_pkg::ST_RANK) begin
      rd_idx = chunk_word_q;
    end else begin
      rd_idx = widx_q;
    end
  end

  assign word_rd    = words_q[rd_idx];
  assign word_pad   = sbrs_pkg::pop_word_t'(word_rd);
  assign below_mask = (sbrs_pkg::pop_word_t'(1) << chunk_bit_q) - sbrs_pkg::pop_word_t'(1);
  assign byte_slice = 8'(word_pad >> {byte_q, 3'b000});

  // Route the shared counter operand
  always_comb begin
    unique case (state_q)
      sbrs_pkg::ST_RANK:   pop_opnd = word_pad & below_mask;
      sbrs_pkg::ST_SELECT: pop_opnd = sbrs_pkg::pop_word_t'(byte_slice);
      default:             pop_opnd = word_pad;
    endcase
  end

  sbrs_popcnt u_popcnt (
    .operand_i (pop_opnd),
    .count_o   (pop_cnt)
  );

  // Locate the wanted set bit inside the current byte
  always_comb begin
    loc_cnt = '0;
    loc_j   = '0;
    loc_hit = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (byte_slice[j]) begin
        if (!loc_hit && (loc_cnt == {1'b0, need_q[2:0]})) begin
          loc_hit = 1'b1;
          loc_j   = 3'(j);
        end
        loc_cnt = loc_cnt + 4'd1;
      end
    end
  end

  assign scan_sum     = {1'b0, tot_q} + (ACC_W+1)'(pop_cnt);
  assign rank_sum     = rank_acc_q + ACC_W'(pop_cnt);
  assign need_full    = ACC_W'(pos_q) - tot_q;
  assign scan_last    = (widx_q == WIDX_W'(NUM_WORDS - 1));
  assign is_rank_op   = (op_q == sbrs_pkg::OP_INSERT) || (op_q == sbrs_pkg::OP_LOOKUP);
  assign scan_hit     = (op_q == sbrs_pkg::OP_REMOVE) && !found_q
                        && (scan_sum > (ACC_W+1)'(pos_q));
  assign sel_bit      = BIT_IDX_W'(16'(byte_q) * 16'd8 + 16'(loc_j));
  assign removed_full = 16'(sel_word_q) * 16'(WORD_BITS) + 16'(sel_bit);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    chunk_word_d = chunk_word_q;
    chunk_bit_d = chunk_bit_q;
    in_range_d  = in_range_q;
    pos_d       = pos_q;
    widx_d      = widx_q;
    tot_d       = tot_q;
    rank_acc_d  = rank_acc_q;
    found_d     = found_q;
    sel_word_d  = sel_word_q;
    need_d      = need_q;
    byte_d      = byte_q;
    res_valid_d = 1'b0;
    was_d       = 1'b0;
    rank_d      = '0;
    removed_d   = '0;
    empty_d     = 1'b0;
    fault_d     = 1'b0;
    wr_en       = 1'b0;
    clr_all     = 1'b0;
    wr_idx      = rd_idx;
    wr_data     = word_rd;

    unique case (state_q)
      sbrs_pkg::ST_IDLE: begin
        // Take a new item
        if (start) begin
          op_d         = sbrs_pkg::op_e'(op_i);
          chunk_word_d = WIDX_W'(chunk_div);
          chunk_bit_d  = BIT_IDX_W'(chunk_rem);
          in_range_d   = ({29'd0, chunk_div} < 32'(NUM_WORDS));
          pos_d        = slot_position_i;
          widx_d       = '0;
          tot_d        = '0;
          rank_acc_d   = '0;
          found_d      = 1'b0;
          if (op_i == sbrs_pkg::OP_CLEAR) begin
            clr_all     = 1'b1;
            res_valid_d = 1'b1;
            empty_d     = 1'b1;
          end else begin
            state_d = sbrs_pkg::ST_SCAN;
          end
        end
      end

      sbrs_pkg::ST_SCAN: begin
        // Accumulate population, prefix rank and the select word
        tot_d = ACC_W'(scan_sum);
        if (is_rank_op && in_range_q && (widx_q < chunk_word_q)) begin
          rank_acc_d = rank_sum;
        end
        if (scan_hit) begin
          found_d    = 1'b1;
          sel_word_d = widx_q;
          need_d     = need_full[sbrs_pkg::FIELD_W-1:0];
        end
        if (scan_last) begin
          if (op_q == sbrs_pkg::OP_REMOVE) begin
            if (scan_hit || found_q) begin
              state_d = sbrs_pkg::ST_SELECT;
              byte_d  = '0;
            end else begin
              res_valid_d = 1'b1;
              fault_d     = 1'b1;
              empty_d     = (scan_sum == '0);
              state_d     = sbrs_pkg::ST_IDLE;
            end
          end else if (in_range_q) begin
            state_d = sbrs_pkg::ST_RANK;
          end else begin
            res_valid_d = 1'b1;
            rank_d      = scan_sum[sbrs_pkg::FIELD_W-1:0];
            empty_d     = (scan_sum == '0);
            state_d     = sbrs_pkg::ST_IDLE;
          end
        end else begin
          widx_d = widx_q + WIDX_W'(1);
        end
      end

      sbrs_pkg::ST_RANK: begin
        // Count below the chunk, test its bit and set it on insert
        res_valid_d = 1'b1;
        was_d       = word_rd[chunk_bit_q];
        rank_d      = rank_sum[sbrs_pkg::FIELD_W-1:0];
        if (op_q == sbrs_pkg::OP_INSERT) begin
          wr_en   = 1'b1;
          wr_idx  = chunk_word_q;
          wr_data = word_rd | (WORD_BITS'(1) << chunk_bit_q);
          empty_d = 1'b0;
        end else begin
          empty_d = (tot_q == '0);
        end
        state_d = sbrs_pkg::ST_IDLE;
      end

      sbrs_pkg::ST_SELECT: begin
        // Walk the selected word a byte at a time
        if ({1'b0, need_q} < pop_cnt) begin
          wr_en       = 1'b1;
          wr_idx      = sel_word_q;
          wr_data     = word_rd & ~(WORD_BITS'(1) << sel_bit);
          res_valid_d = 1'b1;
          was_d       = 1'b1;
          removed_d   = removed_full[sbrs_pkg::FIELD_W-1:0];
          empty_d     = (tot_q == ACC_W'(1));
          state_d     = sbrs_pkg::ST_IDLE;
        end else begin
          need_d = need_q - sbrs_pkg::FIELD_W'(pop_cnt);
          byte_d = byte_q + BYTE_IDX_W'(1);
        end
      end

      default: begin
        state_d = sbrs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbrs_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Item working registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    chunk_word_q <= chunk_word_d;
    chunk_bit_q  <= chunk_bit_d;
    in_range_q   <= in_range_d;
    pos_q        <= pos_d;
    widx_q       <= widx_d;
    tot_q        <= tot_d;
    rank_acc_q   <= rank_acc_d;
    found_q      <= found_d;
    sel_word_q   <= sel_word_d;
    need_q       <= need_d;
    byte_q       <= byte_d;
  end

  // Result payload, loaded with the strobe
  always_ff @(posedge clk_i) begin
    if (res_valid_d) begin
      was_q     <= was_d;
      rank_q    <= rank_d;
      removed_q <= removed_d;
      empty_q   <= empty_d;
      fault_q   <= fault_d;
    end
  end

  // Presence words: clear all or write one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_q[i] <= '0;
      end
    end else if (clr_all) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_q[i] <= '0;
      end
    end else if (wr_en) begin
      words_q[wr_idx] <= wr_data;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign was_present_o   = was_q;
  assign rank_o          = rank_q;
  assign removed_chunk_o = removed_q;
  assign node_empty_o    = empty_q;
  assign fault_o         = fault_q;

  // Checks
  `SBRS_ASSERT_IMPL(a_result_when_idle, clk_i, rst_ni, result_valid_o, state_q == sbrs_pkg::ST_IDLE)
  `SBRS_ASSERT_IMPL(a_fault_clean, clk_i, rst_ni, result_valid_o && fault_o, !was_present_o && (removed_chunk_o == 6'd0))
  `SBRS_ASSERT_NEXT(a_start_goes_busy, clk_i, rst_ni, start && !busy && (op_i != sbrs_pkg::OP_CLEAR), busy)
  `SBRS_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, start && !busy && (op_i == sbrs_pkg::OP_CLEAR), result_valid_o && node_empty_o && !busy)

endmodule

// ----- src/sbrs_popcnt.sv -----
// Shared population counter of the rank/select unit: 64-bit operand in,
// set-bit count out. Depends on sbrs_pkg.
`timescale 1ns / 1ps

module sbrs_popcnt (
  input  sbrs_pkg::pop_word_t operand_i,
  output sbrs_pkg::pop_cnt_t  count_o
);

  sbrs_pkg::pop_word_t pairs;
  sbrs_pkg::pop_word_t quads;
  sbrs_pkg::pop_word_t bytes;
  sbrs_pkg::pop_cnt_t  total;

  // Fold bits into 2-, 4- and 8-bit partial counts
  assign pairs = operand_i - ((operand_i >> 1) & 64'h5555_5555_5555_5555);
  assign quads = (pairs & 64'h3333_3333_3333_3333)
               + ((pairs >> 2) & 64'h3333_3333_3333_3333);
  assign bytes = (quads + (quads >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;

  // Add the eight byte counts
  always_comb begin
    total = '0;
    for (int k = 0; k < sbrs_pkg::POP_W / 8; k++) begin
      total = total + sbrs_pkg::pop_cnt_t'(bytes[8*k +: 8]);
    end
  end

  assign count_o = total;

endmodule

// ----- dv/tb_sparse_bitmap_rank_select_unit.sv -----
// Self-checking testbench for the sparse bitmap rank/select unit: a directed table, then
// random fill/drain traffic; items checked against a bitmap predictor or pinned result.
// Depends on sbrs_pkg and the top level sparse_bitmap_rank_select_unit.
`timescale 1ns / 1ps

module tb_sparse_bitmap_rank_select_unit;
  import sbrs_pkg::*;

  localparam int BITMAP_BITS  = 64;    // every 6-bit chunk fits in the two words
  localparam int RANDOM_ITEMS = 930;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int NUM_ROWS     = 19;

  typedef struct packed {
    logic       was_present;
    logic [5:0] rank;
    logic [5:0] removed_chunk;
    logic       node_empty;
    logic       fault;
  } bitmap_result_t;

  typedef struct packed {
    op_e            op;
    logic [5:0]     chunk;
    logic [5:0]     slot;
    logic           pinned;
    bitmap_result_t want;
  } stim_row_t;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } traffic_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] op_i = OP_LOOKUP;
  logic [5:0] chunk_value_i = '0;
  logic [5:0] slot_position_i = '0;
  logic       result_valid_o;
  logic       was_present_o;
  logic [5:0] rank_o;
  logic [5:0] removed_chunk_o;
  logic       node_empty_o;
  logic       fault_o;

  // Hand-typed expectation travelling with the item currently driven
  logic           pin_expected = 1'b0;
  bitmap_result_t pinned_result = '0;

  logic [BITMAP_BITS-1:0] presence_bits = '0;
  bitmap_result_t         pending_results[$];
  int                     error_count = 0;
  int                     stall_cycles = 0;
  stim_row_t              directed_rows[NUM_ROWS];

  sparse_bitmap_rank_select_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .chunk_value_i   (chunk_value_i),
    .slot_position_i (slot_position_i),
    .result_valid_o  (result_valid_o),
    .was_present_o   (was_present_o),
    .rank_o          (rank_o),
    .removed_chunk_o (removed_chunk_o),
    .node_empty_o    (node_empty_o),
    .fault_o         (fault_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one item to the predicted bitmap and return its result
  function automatic bitmap_result_t apply_to_bitmap(op_e op, logic [5:0] chunk,
                                                     logic [5:0] slot);
    bitmap_result_t res;
    int             seen;
    res  = '0;
    seen = 0;
    case (op)
      OP_INSERT, OP_LOOKUP: begin
        res.rank        = 6'($countones(presence_bits & ((64'd1 << chunk) - 64'd1)));
        res.was_present = presence_bits[chunk];
        if (op == OP_INSERT) presence_bits[chunk] = 1'b1;
      end
      OP_REMOVE: begin
        if (int'(slot) >= $countones(presence_bits)) begin
          res.fault = 1'b1;
        end else begin
          // walk to the slot-th set bit in chunk order
          for (int c = 0; c < BITMAP_BITS; c++) begin
            if (presence_bits[c]) begin
              if (seen == int'(slot)) begin
                presence_bits[c]  = 1'b0;
                res.removed_chunk = 6'(c);
                res.was_present   = 1'b1;
                break;
              end
              seen++;
            end
          end
        end
      end
      default: presence_bits = '0;
    endcase
    res.node_empty = (presence_bits == '0);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Check results against the oldest expectation, then predict accepted items
  always @(posedge clk_i) begin
    bitmap_result_t got, want, predicted;
    if (rst_ni) begin
      stall_cycles = stall_cycles + 1;
      if (result_valid_o) begin
        stall_cycles = 0;
        got = '{was_present_o, rank_o, removed_chunk_o, node_empty_o, fault_o};
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending (packed fields)", int'(got), 0);
        end else begin
          want = pending_results.pop_front();
          if (got.was_present !== want.was_present)
            report_mismatch("was_present", got.was_present, want.was_present);
          if (got.rank !== want.rank)
            report_mismatch("rank", got.rank, want.rank);
          if (got.removed_chunk !== want.removed_chunk)
            report_mismatch("removed_chunk", got.removed_chunk, want.removed_chunk);
          if (got.node_empty !== want.node_empty)
            report_mismatch("node_empty", got.node_empty, want.node_empty);
          if (got.fault !== want.fault)
            report_mismatch("fault", got.fault, want.fault);
        end
      end
      if (start && !busy) begin
        stall_cycles = 0;
        predicted = apply_to_bitmap(op_e'(op_i), chunk_value_i, slot_position_i);
        pending_results.insert(pending_results.size(),
                               pin_expected ? pinned_result : predicted);
      end
    end
  end

  // Abort when nothing moves for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // Drive one item at the falling edge and hold it until accepted
  task automatic send_item(op_e op, logic [5:0] chunk, logic [5:0] slot, logic pinned,
                           bitmap_result_t want, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start           <= 1'b1;
    op_i            <= op;
    chunk_value_i   <= chunk;
    slot_position_i <= slot;
    pin_expected    <= pinned;
    pinned_result   <= want;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    op_e        op;
    logic [5:0] chunk, slot;
    traffic_e   mode;
    int         pop, dice, idle_pct;

    // Directed rows: empty-node corners, both chunk extremes, fault and clear
    directed_rows = '{
      '{OP_LOOKUP, 6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 6'd0, 1'b1, 1'b0}},
      '{OP_REMOVE, 6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 6'd0, 1'b1, 1'b1}},
      '{OP_CLEAR,  6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 6'd0, 1'b1, 1'b0}},
      '{OP_INSERT, 6'd63, 6'd63, 1'b1, '{1'b0, 6'd0, 6'd0, 1'b0, 1'b0}},
      '{OP_INSERT, 6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 6'd0, 1'b0, 1'b0}},
      '{OP_INSERT, 6'd62, 6'd0,  1'b0, '0},
      '{OP_INSERT, 6'd63, 6'd0,  1'b0, '0},
      '{OP_LOOKUP, 6'd63, 6'd0,  1'b0, '0},
      '{OP_LOOKUP, 6'd1,  6'd0,  1'b0, '0},
      '{OP_INSERT, 6'd42, 6'd21, 1'b0, '0},
      '{OP_INSERT, 6'd21, 6'd42, 1'b0, '0},
      '{OP_REMOVE, 6'd0,  6'd63, 1'b1, '{1'b0, 6'd0, 6'd0, 1'b0, 1'b1}},
      '{OP_REMOVE, 6'd0,  6'd4,  1'b0, '0},
      '{OP_REMOVE, 6'd63, 6'd0,  1'b0, '0},
      '{OP_LOOKUP, 6'd63, 6'd0,  1'b0, '0},
      '{OP_CLEAR,  6'd63, 6'd63, 1'b1, '{1'b0, 6'd0, 6'd0, 1'b1, 1'b0}},
      '{OP_LOOKUP, 6'd63, 6'd0,  1'b1, '{1'b0, 6'd0, 6'd0, 1'b1, 1'b0}},
      '{OP_INSERT, 6'd5,  6'd0,  1'b1, '{1'b0, 6'd0, 6'd0, 1'b0, 1'b0}},
      '{OP_REMOVE, 6'd5,  6'd0,  1'b0, '0}
    };

    // Hold reset, then release it away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].chunk, directed_rows[i].slot,
                directed_rows[i].pinned, directed_rows[i].want, 37);

    // Random traffic in bursts that fill, drain or mix the bitmap
    mode = MODE_MIXED;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) mode = traffic_e'($urandom_range(2));
      idle_pct = (n < RANDOM_ITEMS / 3) ? 37 : (n < 2 * RANDOM_ITEMS / 3) ? 58 : 0;
      pop   = $countones(presence_bits);
      dice  = $urandom_range(99);
      chunk = 6'($urandom);
      slot  = 6'($urandom);
      case (mode)
        MODE_FILL: begin
          if (dice < 75) begin
            op = OP_INSERT;
            // mostly pick an absent chunk so the node really fills up
            if (dice < 60 && pop < BITMAP_BITS)
              while (presence_bits[chunk]) chunk = 6'($urandom);
          end else if (dice < 95) begin
            op = OP_LOOKUP;
          end else begin
            op = OP_REMOVE;
          end
        end
        MODE_DRAIN: begin
          if (dice < 75) begin
            op = OP_REMOVE;
            if (pop > 0) slot = 6'($urandom_range(pop - 1));
          end else if (dice < 85) begin
            op = OP_REMOVE;
            if (pop < BITMAP_BITS) slot = 6'($urandom_range(BITMAP_BITS - 1, pop));
          end else begin
            op = OP_LOOKUP;
          end
        end
        default: begin
          if (dice < 3) op = OP_CLEAR;
          else op = op_e'($urandom_range(2));
          if (op == OP_REMOVE && pop > 0 && dice < 70) slot = 6'($urandom_range(pop - 1));
        end
      endcase
      send_item(op, chunk, slot, 1'b0, '0, idle_pct);
    end
    @(negedge clk_i);
    start <= 1'b0;

    // Let every result land, then allow for a stray one
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
